FILE: rtl/ksb_pkg.sv
package ksb_pkg;

   localparam logic signed [1:0] SYM_POS  = 2'sb01;
   localparam logic signed [1:0] SYM_ZERO = 2'sb00;
   localparam logic signed [1:0] SYM_NEG  = 2'sb11;

   // (2/n) by n mod 8
   localparam logic signed [1:0] MOD8_SIGN [8] = '{
      SYM_ZERO, SYM_POS, SYM_ZERO, SYM_NEG, SYM_ZERO, SYM_NEG, SYM_ZERO, SYM_POS
   };

   typedef logic signed [1:0] symbol_type;

   function automatic symbol_type sym_mul(input symbol_type k, input symbol_type m);
      symbol_type r;
      r = k;
      if (m == SYM_ZERO) begin
         r = SYM_ZERO;
      end else if (m == SYM_NEG) begin
         r = -k;
      end
      return r;
   endfunction

endpackage

FILE: rtl/kronecker_symbol_binary.sv
// kronecker symbol (a/b), binary algorithm, one subtractor shared by the negate and
// subtract steps. setup negates a, then b, then checks for early results; then factors
// of two are stripped from b; the main loop shifts a or subtracts, swapping if a < b.
// the result strobe comes in the cycle after the last step; busy is low in that
// cycle, so the next item may be started then. the receiver cannot stall.
// synchronous reset returns the sequencer to idle and clears the result strobe.
module kronecker_symbol_binary
   import ksb_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [63:0] req_a_value,
   input  logic signed [63:0] req_b_value,
   output logic               rsp_valid,
   output logic signed [1:0]  rsp_symbol
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_NEGA   = 3'd1;
   localparam logic [2:0] S_NEGB   = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_BSTRIP = 3'd4;
   localparam logic [2:0] S_LOOP   = 3'd5;
   localparam logic [2:0] S_SUB    = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [WIDTH-1:0] am_ff, am_in;
   logic [WIDTH-1:0] bm_ff, bm_in;
   logic             aneg_ff, aneg_in;
   logic             bneg_ff, bneg_in;
   logic             par_ff, par_in;
   symbol_type       k_ff, k_in;
   logic             rsp_valid_ff, rsp_valid_in;
   symbol_type       rsp_symbol_ff, rsp_symbol_in;

   logic [WIDTH-1:0] alu_x;
   logic [WIDTH-1:0] alu_y;
   logic [WIDTH-1:0] alu_diff;
   logic             alu_borrow;

   // negate steps take 0 - x, all others am - bm
   always_comb begin
      alu_x = am_ff;
      alu_y = bm_ff;
      if (state_ff == S_NEGA) begin
         alu_x = '0;
         alu_y = am_ff;
      end else if (state_ff == S_NEGB) begin
         alu_x = '0;
         alu_y = bm_ff;
      end
   end

   ksb_sub #(
      .WIDTH(WIDTH)
   ) u_sub (
      .x_value(alu_x),
      .y_value(alu_y),
      .diff   (alu_diff),
      .borrow (alu_borrow)
   );

   always_comb begin
      symbol_type k_tmp;
      state_in      = state_ff;
      am_in         = am_ff;
      bm_in         = bm_ff;
      aneg_in       = aneg_ff;
      bneg_in       = bneg_ff;
      par_in        = par_ff;
      k_in          = k_ff;
      rsp_valid_in  = 1'b0;
      rsp_symbol_in = rsp_symbol_ff;
      k_tmp         = k_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               am_in    = req_a_value[WIDTH-1:0];
               bm_in    = req_b_value[WIDTH-1:0];
               aneg_in  = req_a_value[WIDTH-1];
               bneg_in  = req_b_value[WIDTH-1];
               state_in = S_NEGA;
            end
         end
         S_NEGA: begin
            if (aneg_ff) begin
               am_in = alu_diff;
            end
            state_in = S_NEGB;
         end
         S_NEGB: begin
            if (bneg_ff) begin
               bm_in = alu_diff;
            end
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (bm_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = (am_ff == WIDTH'(1)) ? SYM_POS : SYM_ZERO;
               state_in      = S_IDLE;
            end else if (!am_ff[0] && !bm_ff[0]) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = SYM_ZERO;
               state_in      = S_IDLE;
            end else begin
               k_in     = (aneg_ff && bneg_ff) ? SYM_NEG : SYM_POS;
               par_in   = 1'b0;
               state_in = S_BSTRIP;
            end
         end
         S_BSTRIP: begin
            if (!bm_ff[0]) begin
               bm_in  = bm_ff >> 1;
               par_in = ~par_ff;
            end else begin
               if (par_ff) begin
                  k_tmp = sym_mul(k_tmp, MOD8_SIGN[am_ff[2:0]]);
               end
               if (aneg_ff && bm_ff[1]) begin
                  k_tmp = -k_tmp;
               end
               k_in     = k_tmp;
               par_in   = 1'b0;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (am_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = (bm_ff == WIDTH'(1)) ? k_ff : SYM_ZERO;
               state_in      = S_IDLE;
            end else if (!am_ff[0]) begin
               am_in  = am_ff >> 1;
               par_in = ~par_ff;
            end else begin
               if (par_ff) begin
                  k_tmp = sym_mul(k_tmp, MOD8_SIGN[bm_ff[2:0]]);
               end
               par_in = 1'b0;
               if (alu_borrow) begin
                  // a < b: swap with reciprocity sign, subtract next cycle
                  am_in = bm_ff;
                  bm_in = am_ff;
                  if (am_ff[1] && bm_ff[1]) begin
                     k_tmp = -k_tmp;
                  end
                  state_in = S_SUB;
               end else begin
                  am_in = alu_diff;
               end
               k_in = k_tmp;
            end
         end
         S_SUB: begin
            am_in    = alu_diff;
            state_in = S_LOOP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      am_ff         <= am_in;
      bm_ff         <= bm_in;
      aneg_ff       <= aneg_in;
      bneg_ff       <= bneg_in;
      par_ff        <= par_in;
      k_ff          <= k_in;
      rsp_symbol_ff <= rsp_symbol_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;

   // a result only ever ends a run of work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without preceding work");

   a_symbol_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_symbol == SYM_POS || rsp_symbol == SYM_ZERO ||
                     rsp_symbol == SYM_NEG))
      else $error("illegal symbol code");

   a_start_takes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start work");

   // b stays odd through the main loop
   a_b_odd_in_loop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOP || state_ff == S_SUB) |-> bm_ff[0])
      else $error("even b in main loop");

endmodule

FILE: rtl/ksb_sub.sv
module ksb_sub #(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0] x_value,
   input  logic [WIDTH-1:0] y_value,
   output logic [WIDTH-1:0] diff,
   output logic             borrow
);

   // borrow out means x < y
   assign {borrow, diff} = {1'b0, x_value} - {1'b0, y_value};

endmodule

FILE: tb/kronecker_symbol_binary_tb.sv
module kronecker_symbol_binary_tb;
   import ksb_pkg::*;

   localparam int WIDTH = 64;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 300;
   localparam int ITEMS_PER_PHASE = 490;
   localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_VAL = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_ONE = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [63:0] a;
      logic [63:0] b;
      logic        known;
      symbol_type  sym;
   } directed_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [63:0] req_a_value;
   logic signed [63:0] req_b_value;
   logic               rsp_valid;
   logic signed [1:0]  rsp_symbol;

   symbol_type pending_symbols [$];
   int         mismatch_count = 0;

   // known rows are readable straight off the definition, the rest go through the predictor
   directed_row_type directed_rows [22] = '{
      '{64'd1,       64'd0,       1'b1, SYM_POS},
      '{NEG_ONE,     64'd0,       1'b1, SYM_POS},
      '{64'd0,       64'd0,       1'b1, SYM_ZERO},
      '{64'd2,       64'd0,       1'b1, SYM_ZERO},
      '{MIN_VAL,     64'd0,       1'b1, SYM_ZERO},
      '{64'd2,       64'd4,       1'b1, SYM_ZERO},
      '{64'd0,       64'd2,       1'b1, SYM_ZERO},
      '{MIN_VAL,     MIN_VAL,     1'b1, SYM_ZERO},
      '{MAX_VAL,     MAX_VAL,     1'b1, SYM_ZERO},
      '{64'd1,       64'd1,       1'b1, SYM_POS},
      '{64'd0,       64'd1,       1'b1, SYM_POS},
      '{NEG_ONE,     NEG_ONE,     1'b1, SYM_NEG},
      '{MIN_VAL,     64'd1,       1'b0, SYM_ZERO},
      '{64'd2,       64'd3,       1'b0, SYM_ZERO},
      '{64'd3,       64'd2,       1'b0, SYM_ZERO},
      '{-64'sd3,     64'd7,       1'b0, SYM_ZERO},
      '{64'd5,       -64'sd8,     1'b0, SYM_ZERO},
      '{MAX_VAL,     MIN_VAL,     1'b0, SYM_ZERO},
      '{MIN_VAL,     MAX_VAL,     1'b0, SYM_ZERO},
      '{64'd7,       64'd1_000_000_007, 1'b0, SYM_ZERO},
      '{-64'sd5,     -64'sd3,     1'b0, SYM_ZERO},
      '{MIN_VAL,     NEG_ONE,     1'b0, SYM_ZERO}
   };

   int idle_pct_by_phase [4] = '{0, 76, 18, 0};

   kronecker_symbol_binary #(.WIDTH(WIDTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_a_value (req_a_value),
      .req_b_value (req_b_value),
      .rsp_valid   (rsp_valid),
      .rsp_symbol  (rsp_symbol)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // (2/n) for odd n, zero for even n
   function automatic int two_sign(logic [2:0] low_bits);
      case (low_bits)
         3'd1, 3'd7: begin
            return 1;
         end
         3'd3, 3'd5: begin
            return -1;
         end
         default: begin
            return 0;
         end
      endcase
   endfunction

   function automatic symbol_type kronecker_of(logic [63:0] a_in, logic [63:0] b_in);
      logic [63:0] mask;
      logic [63:0] am;
      logic [63:0] bm;
      logic [63:0] tmp;
      logic        a_neg;
      logic        b_neg;
      int          k;
      int          twos;
      mask = {64{1'b1}} >> (64 - WIDTH);
      am = a_in & mask;
      bm = b_in & mask;
      a_neg = am[WIDTH-1];
      b_neg = bm[WIDTH-1];
      if (a_neg) begin
         am = (~am + 64'd1) & mask;
      end
      if (b_neg) begin
         bm = (~bm + 64'd1) & mask;
      end
      if (bm == 64'd0) begin
         return (am == 64'd1) ? SYM_POS : SYM_ZERO;
      end
      if (!am[0] && !bm[0]) begin
         return SYM_ZERO;
      end
      k = (a_neg && b_neg) ? -1 : 1;
      twos = 0;
      while (!bm[0]) begin
         twos++;
         bm = bm >> 1;
      end
      if (twos[0]) begin
         k = k * two_sign(am[2:0]);
      end
      if (a_neg && bm[1]) begin
         k = -k;
      end
      while (am != 64'd0) begin
         twos = 0;
         while (!am[0]) begin
            twos++;
            am = am >> 1;
         end
         if (twos[0]) begin
            k = k * two_sign(bm[2:0]);
         end
         // reciprocity flip when both are 3 mod 4
         if (am < bm) begin
            tmp = am;
            am = bm;
            bm = tmp;
            if (am[1] && bm[1]) begin
               k = -k;
            end
         end
         am = am - bm;
      end
      return (bm == 64'd1) ? symbol_type'(k) : SYM_ZERO;
   endfunction

   function automatic logic [63:0] pick_operand();
      logic signed [63:0] v;
      case ($urandom_range(0, 7))
         0, 1: begin
            v = {$urandom, $urandom};
         end
         2: begin
            v = 64'($urandom_range(0, 200));
            v = v - 64'sd100;
         end
         3: begin
            case ($urandom_range(0, 6))
               0: v = 64'd0;
               1: v = 64'd1;
               2: v = NEG_ONE;
               3: v = MIN_VAL;
               4: v = MAX_VAL;
               5: v = MIN_VAL + 64'd1;
               default: v = MAX_VAL - 64'd1;
            endcase
         end
         4: begin
            v = 64'd1 << $urandom_range(0, 63);
            if ($urandom_range(0, 1) == 1) begin
               v = -v;
            end
         end
         5: begin
            v = {$urandom, $urandom} << $urandom_range(0, 62);
         end
         6: begin
            v = {32'd0, $urandom};
            if ($urandom_range(0, 1) == 1) begin
               v = -v;
            end
         end
         default: begin
            v = {{32{1'b0}}, $urandom} * $urandom_range(1, 15);
         end
      endcase
      return v;
   endfunction

   // expects to be called at a falling edge and returns at one
   task automatic drive_item(logic [63:0] a, logic [63:0] b, symbol_type sym, int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         req_a_value <= {$urandom, $urandom};
         req_b_value <= {$urandom, $urandom};
         @(negedge clock);
      end
      start <= 1'b1;
      req_a_value <= a;
      req_b_value <= b;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      pending_symbols.push_back(sym);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (rsp_valid === 1'b1) begin
         if (pending_symbols.size() == 0) begin
            $error("symbol: unexpected item, got %0d", rsp_symbol);
            mismatch_count++;
         end else begin
            symbol_type want;
            want = pending_symbols.pop_front();
            if (rsp_symbol !== want) begin
               $error("symbol: expected %0d, got %0d", want, rsp_symbol);
               mismatch_count++;
            end
         end
      end
   end

   // ends the run when neither side moves for too long
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      logic [63:0] a;
      logic [63:0] b;
      symbol_type  sym;
      reset = 1'b1;
      start = 1'b0;
      req_a_value = '0;
      req_b_value = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         a = directed_rows[i].a;
         b = directed_rows[i].b;
         sym = directed_rows[i].known ? directed_rows[i].sym : kronecker_of(a, b);
         drive_item(a, b, sym, 0);
      end

      foreach (idle_pct_by_phase[p]) begin
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            a = pick_operand();
            b = pick_operand();
            // zero b now and then, and sometimes force both even
            case ($urandom_range(0, 15))
               0: b = 64'd0;
               1: begin
                  a[0] = 1'b0;
                  b[0] = 1'b0;
               end
               default: ;
            endcase
            drive_item(a, b, kronecker_of(a, b), idle_pct_by_phase[p]);
         end
      end
      start <= 1'b0;

      while (pending_symbols.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: kronecker_symbol_binary.f
rtl/ksb_pkg.sv
rtl/ksb_sub.sv
rtl/kronecker_symbol_binary.sv
tb/kronecker_symbol_binary_tb.sv
